// ===== hw/rtl/texture_mip_size_calc_macros.svh =====
// Assertion helpers for the mip size calculator.
`ifndef TEXTURE_MIP_SIZE_CALC_MACROS_SVH
`define TEXTURE_MIP_SIZE_CALC_MACROS_SVH

// Same-cycle implication.
`define TMSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TMSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tmsc_pkg.sv =====
package tmsc_pkg;

   localparam int unsigned DIM_W           = 14;
   localparam int unsigned FMT_W           = 6;
   localparam int unsigned LEVEL_W         = 4;
   localparam int unsigned COUNT_W         = 31;
   localparam int unsigned LG_W            = 3;
   localparam int unsigned MAX_DIM_DEFAULT = 8192;

   typedef enum logic [FMT_W-1:0] {
      FMT_R8G8B8A8               = 6'd0,
      FMT_R8G8B8X8               = 6'd1,
      FMT_R8G8B8                 = 6'd2,
      FMT_R5G5B5A1               = 6'd3,
      FMT_R5G6B5                 = 6'd4,
      FMT_R4G4B4A4               = 6'd5,
      FMT_A16R16G16B16           = 6'd6,
      FMT_A32R32G32B32           = 6'd7,
      FMT_R8                     = 6'd8,
      FMT_R16                    = 6'd9,
      FMT_DXT1                   = 6'd10,
      FMT_DXT3                   = 6'd11,
      FMT_DXT5                   = 6'd12,
      FMT_PVRTC_4BPP_RGBA        = 6'd13,
      FMT_PVRTC_2BPP_RGBA        = 6'd14,
      FMT_PVRTC2_4BPP_RGB        = 6'd15,
      FMT_PVRTC2_4BPP_RGBA       = 6'd16,
      FMT_PVRTC2_2BPP_RGB        = 6'd17,
      FMT_PVRTC2_2BPP_RGBA       = 6'd18,
      FMT_ATC_RGB                = 6'd19,
      FMT_ATC_RGBA_EXPLICIT      = 6'd20,
      FMT_ATC_RGBA_INTERPOLATED  = 6'd21,
      FMT_ETC1                   = 6'd22,
      FMT_ETC2_R8G8B8            = 6'd23,
      FMT_ETC2_R8G8B8A8          = 6'd24,
      FMT_ETC2_R8G8B8A1          = 6'd25,
      FMT_EAC_R11_UNSIGNED       = 6'd26,
      FMT_EAC_R11_SIGNED         = 6'd27,
      FMT_EAC_R11G11_UNSIGNED    = 6'd28,
      FMT_EAC_R11G11_SIGNED      = 6'd29,
      FMT_D16                    = 6'd30,
      FMT_D24S8                  = 6'd31,
      FMT_R32F                   = 6'd32,
      FMT_RG32F                  = 6'd33,
      FMT_RGBA32F                = 6'd34
   } fmt_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_CEIL,
      KIND_FLOOR4
   } kind_type;

   // bytes = (1 << byte_lg) * (mul3 ? 3 : 1); block sides are 1 << *_lg
   typedef struct packed {
      kind_type        kind;
      logic [LG_W-1:0] bw_lg;
      logic [LG_W-1:0] bh_lg;
      logic [LG_W-1:0] byte_lg;
      logic            mul3;
   } size_desc_type;

   typedef struct packed {
      logic            defined;
      logic            blk;
      logic [LG_W-1:0] byte_lg;
      logic            mul3;
   } stride_desc_type;

   function automatic size_desc_type size_desc(input logic [FMT_W-1:0] code);
      size_desc_type d;
      d = '{kind: KIND_CEIL, bw_lg: 3'd0, bh_lg: 3'd0, byte_lg: 3'd0, mul3: 1'b0};
      case (fmt_type'(code))
         FMT_R8G8B8A8, FMT_R8G8B8X8, FMT_D24S8, FMT_R32F: d.byte_lg = 3'd2;
         FMT_R8G8B8: d.mul3 = 1'b1;
         FMT_R5G5B5A1, FMT_R5G6B5, FMT_R4G4B4A4, FMT_R16, FMT_D16: d.byte_lg = 3'd1;
         FMT_A16R16G16B16, FMT_RG32F: d.byte_lg = 3'd3;
         FMT_A32R32G32B32, FMT_RGBA32F: d.byte_lg = 3'd4;
         FMT_R8: d.byte_lg = 3'd0;
         FMT_DXT1, FMT_ETC1, FMT_ETC2_R8G8B8, FMT_EAC_R11_UNSIGNED,
         FMT_EAC_R11_SIGNED: begin
            d.kind    = KIND_FLOOR4;
            d.byte_lg = 3'd3;
         end
         FMT_DXT3, FMT_DXT5, FMT_ETC2_R8G8B8A8, FMT_ETC2_R8G8B8A1,
         FMT_EAC_R11G11_UNSIGNED, FMT_EAC_R11G11_SIGNED: begin
            d.kind    = KIND_FLOOR4;
            d.byte_lg = 3'd4;
         end
         FMT_PVRTC_4BPP_RGBA: begin
            d.bw_lg   = 3'd3;
            d.bh_lg   = 3'd3;
            d.byte_lg = 3'd5;
         end
         FMT_PVRTC_2BPP_RGBA: begin
            d.bw_lg   = 3'd3;
            d.bh_lg   = 3'd4;
            d.byte_lg = 3'd5;
         end
         FMT_PVRTC2_4BPP_RGB, FMT_PVRTC2_4BPP_RGBA, FMT_ATC_RGB: begin
            d.bw_lg   = 3'd2;
            d.bh_lg   = 3'd2;
            d.byte_lg = 3'd3;
         end
         FMT_PVRTC2_2BPP_RGB, FMT_PVRTC2_2BPP_RGBA: begin
            d.bw_lg   = 3'd3;
            d.bh_lg   = 3'd2;
            d.byte_lg = 3'd3;
         end
         FMT_ATC_RGBA_EXPLICIT, FMT_ATC_RGBA_INTERPOLATED: begin
            d.bw_lg   = 3'd2;
            d.bh_lg   = 3'd2;
            d.byte_lg = 3'd4;
         end
         default: d.kind = KIND_NONE;
      endcase
      return d;
   endfunction

   function automatic stride_desc_type stride_desc(input logic [FMT_W-1:0] code);
      stride_desc_type d;
      d = '{defined: 1'b1, blk: 1'b0, byte_lg: 3'd0, mul3: 1'b0};
      case (fmt_type'(code))
         FMT_R8G8B8A8, FMT_D24S8, FMT_R32F: d.byte_lg = 3'd2;
         FMT_R8G8B8: d.mul3 = 1'b1;
         FMT_R5G5B5A1, FMT_R5G6B5, FMT_R4G4B4A4, FMT_R16, FMT_D16: d.byte_lg = 3'd1;
         FMT_R8: d.byte_lg = 3'd0;
         FMT_DXT1: begin
            d.blk     = 1'b1;
            d.byte_lg = 3'd3;
         end
         FMT_DXT3, FMT_DXT5: begin
            d.blk     = 1'b1;
            d.byte_lg = 3'd4;
         end
         default: d.defined = 1'b0;
      endcase
      return d;
   endfunction

endpackage

// ===== hw/rtl/tmsc_if.sv =====
interface tmsc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [tmsc_pkg::FMT_W-1:0]    format;
   logic [tmsc_pkg::DIM_W-1:0]    width;
   logic [tmsc_pkg::DIM_W-1:0]    height;
   logic [tmsc_pkg::LEVEL_W-1:0]  level;

   modport source (output valid, mode, format, width, height, level, input ready);
   modport sink   (input valid, mode, format, width, height, level, output ready);
endinterface

interface tmsc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tmsc_pkg::COUNT_W-1:0]  byte_count;
   logic                          valid_res;

   modport source (output valid, byte_count, valid_res, input ready);
   modport sink   (input valid, byte_count, valid_res, output ready);
endinterface

// ===== hw/rtl/texture_mip_size_calc.sv =====
// Texture mip level size calculator.
//
// req_if carries one item per handshake: mode (level size or row stride),
// format code, base width and height, and mip level. rsp_if returns one item
// for each request: byte_count and valid_res (cleared for a format that is
// unknown, or that has no row formula in stride mode, with byte_count 0).
//
// Two register stages: a request register and a result register, with the
// extent, block count, one multiply and saturation between them. A result
// moves from the request register into the result register, which drives
// rsp_if; one item is accepted every cycle while the result side takes items.
//
// When rsp_if stalls, the result register holds; the request register still
// takes an item if it is empty, so req_if.ready drops only when both stages
// are full and rsp_if.ready is low.
//
// Reset (synchronous) empties both stages; nothing else needs clearing.
`include "texture_mip_size_calc_macros.svh"

module texture_mip_size_calc #(
   parameter int unsigned MAX_DIM = tmsc_pkg::MAX_DIM_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   tmsc_req_if.sink          req_if,
   tmsc_rsp_if.source        rsp_if
);

   localparam int unsigned EXT_W  = $clog2(MAX_DIM + 1);
   localparam int unsigned PROD_W = 2 * EXT_W;
   localparam int unsigned FULL_W = (PROD_W + 7 > 32) ? PROD_W + 7 : 32;
   localparam int unsigned WIDE_W = tmsc_pkg::DIM_W + 1;

   logic                               s1_valid_ff;
   logic                               s1_mode_ff;
   logic [tmsc_pkg::FMT_W-1:0]         s1_format_ff;
   logic [tmsc_pkg::DIM_W-1:0]         s1_width_ff;
   logic [tmsc_pkg::DIM_W-1:0]         s1_height_ff;
   logic [tmsc_pkg::LEVEL_W-1:0]       s1_level_ff;

   logic                               s2_valid_ff;
   logic [tmsc_pkg::COUNT_W-1:0]       s2_count_ff;
   logic                               s2_ok_ff;
   logic [tmsc_pkg::COUNT_W-1:0]       s2_count_in;
   logic                               s2_ok_in;

   logic                               s1_en;
   logic                               s2_en;

   tmsc_pkg::size_desc_type            sdesc;
   tmsc_pkg::stride_desc_type          tdesc;
   logic [EXT_W-1:0]                   ex;
   logic [EXT_W-1:0]                   ey;
   logic [EXT_W-1:0]                   fa;
   logic [EXT_W-1:0]                   fb;
   logic [tmsc_pkg::LG_W-1:0]          shift;
   logic                               mul3;
   logic [PROD_W-1:0]                  prod;
   logic [FULL_W-1:0]                  scaled;

   function automatic logic [EXT_W-1:0] mip_extent(input logic [tmsc_pkg::DIM_W-1:0] base,
                                                   input logic [tmsc_pkg::LEVEL_W-1:0] lvl);
      logic [WIDE_W-1:0] wide;
      logic [EXT_W-1:0]  clamped;
      logic [EXT_W-1:0]  shifted;
      wide = {1'b0, base};
      if (wide > WIDE_W'(MAX_DIM)) begin
         wide = WIDE_W'(MAX_DIM);
      end
      clamped = EXT_W'(wide);
      shifted = clamped >> lvl;
      return (shifted == '0) ? EXT_W'(1) : shifted;
   endfunction

   function automatic logic [EXT_W-1:0] ceil_blocks(input logic [EXT_W-1:0] e,
                                                    input logic [tmsc_pkg::LG_W-1:0] lg);
      logic [EXT_W:0] s;
      s = {1'b0, e} + (((EXT_W + 1)'(1) << lg) - (EXT_W + 1)'(1));
      return EXT_W'(s >> lg);
   endfunction

   function automatic logic [EXT_W-1:0] floor4_blocks(input logic [EXT_W-1:0] e);
      logic [EXT_W-1:0] n;
      n = e >> 2;
      return (n == '0) ? EXT_W'(1) : n;
   endfunction

   assign s2_en         = !s2_valid_ff || rsp_if.ready;
   assign s1_en         = !s1_valid_ff || s2_en;
   assign req_if.ready  = s1_en;

   assign rsp_if.valid      = s2_valid_ff;
   assign rsp_if.byte_count = s2_count_ff;
   assign rsp_if.valid_res  = s2_ok_ff;

   always_comb begin
      sdesc = tmsc_pkg::size_desc(s1_format_ff);
      tdesc = tmsc_pkg::stride_desc(s1_format_ff);
      ex    = mip_extent(s1_width_ff, s1_level_ff);
      ey    = mip_extent(s1_height_ff, s1_level_ff);
      fa    = ex;
      fb    = ey;
      shift = sdesc.byte_lg;
      mul3  = sdesc.mul3;
      s2_ok_in = 1'b1;
      if (s1_mode_ff) begin
         s2_ok_in = tdesc.defined;
         fa       = tdesc.blk ? ceil_blocks(ex, tmsc_pkg::LG_W'(2)) : ex;
         fb       = EXT_W'(1);
         shift    = tdesc.byte_lg;
         mul3     = tdesc.mul3;
      end else begin
         case (sdesc.kind)
            tmsc_pkg::KIND_FLOOR4: begin
               fa = floor4_blocks(ex);
               fb = floor4_blocks(ey);
            end
            tmsc_pkg::KIND_CEIL: begin
               fa = ceil_blocks(ex, sdesc.bw_lg);
               fb = ceil_blocks(ey, sdesc.bh_lg);
            end
            default: s2_ok_in = 1'b0;
         endcase
      end
      prod   = fa * fb;
      scaled = FULL_W'(prod) << shift;
      if (mul3) begin
         scaled = scaled + (scaled << 1);
      end
      if (!s2_ok_in) begin
         s2_count_in = '0;
      end else if (|scaled[FULL_W-1:tmsc_pkg::COUNT_W]) begin
         s2_count_in = '1;
      end else begin
         s2_count_in = scaled[tmsc_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= req_if.valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
      if (s1_en && req_if.valid) begin
         s1_mode_ff   <= req_if.mode;
         s1_format_ff <= req_if.format;
         s1_width_ff  <= req_if.width;
         s1_height_ff <= req_if.height;
         s1_level_ff  <= req_if.level;
      end
      if (s2_en && s1_valid_ff) begin
         s2_count_ff <= s2_count_in;
         s2_ok_ff    <= s2_ok_in;
      end
   end

   `TMSC_ASSERT_NOW(a_invalid_gives_zero, clock, reset, rsp_if.valid && !rsp_if.valid_res, rsp_if.byte_count == '0, "undefined format must give a zero count")
   `TMSC_ASSERT_NOW(a_defined_nonzero, clock, reset, rsp_if.valid && rsp_if.valid_res, rsp_if.byte_count != '0, "defined result must be at least one byte")
   `TMSC_ASSERT_NEXT(a_stage_advances, clock, reset, s1_valid_ff && s2_en, s2_valid_ff, "item in request stage lost on advance")

endmodule
